### hdl/binary_curve_point_adder_unit_assert.svh
// Assertion macros for the point adder.
`ifndef BINARY_CURVE_POINT_ADDER_UNIT_ASSERT_SVH
`define BINARY_CURVE_POINT_ADDER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BCPA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bcpa assertion failed");

// Next-cycle implication.
`define BCPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bcpa assertion failed");

`endif

### hdl/bcpa_pkg.sv
`default_nettype none
package bcpa_pkg;

  localparam int FIELD_DEGREE = 32;
  localparam int ElemW = FIELD_DEGREE;
  localparam int DegW  = $clog2(FIELD_DEGREE + 1);
  localparam int CntW  = $clog2(FIELD_DEGREE);
  localparam int WordW = 32;

  typedef logic [ElemW-1:0] elem_t;
  typedef logic [WordW-1:0] word_t;

  localparam logic CFG_POLY = 1'b0;
  localparam logic CFG_A    = 1'b1;

  localparam logic [1:0] PH_1 = 2'd0;
  localparam logic [1:0] PH_2 = 2'd1;
  localparam logic [1:0] PH_3 = 2'd2;
  localparam logic [1:0] PH_4 = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RES_P1,
    OP_RES_P2,
    OP_RES_ZERO,
    OP_INV_INIT,
    OP_INV_STEP,
    OP_MUL_INIT,
    OP_MUL_STEP,
    OP_WB,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] phase;
  } cmd_t;

  typedef struct packed {
    logic inf1;
    logic inf2;
    logic same_x;
    logic y_eq;
    logic x1_zero;
    logic inv_done;
    logic mul_last;
  } stat_t;

  function automatic elem_t word_to_elem(word_t w);
    logic [63:0] wide;
    wide = 64'(w);
    return wide[ElemW-1:0];
  endfunction

  function automatic word_t elem_to_word(elem_t e);
    logic [63:0] wide;
    wide = 64'(e);
    return wide[WordW-1:0];
  endfunction

endpackage
`default_nettype wire

### hdl/binary_curve_point_adder_unit.sv
// Affine point adder for y^2 + xy = x^3 + a*x^2 + b over GF(2^FIELD_DEGREE).
// Slave stream carries one request: both points; (0,0) stands for infinity.
// Master stream returns the sum point, (0,0) for infinity.
// cfg_we_i writes register cfg_idx_i: 0 field polynomial without x^M, 1 curve a.
// Special cases (an infinity operand, opposite points, doubling of x=0) skip
// the arithmetic. Otherwise one extended-Euclid inversion (one reduction,
// swap or degree step per cycle) and three multiplies (four when doubling)
// run on the bit-serial shift-and-add unit.
// One request at a time: s_axis_tready is high only while the block is idle.
// The result sits in an output register, so a stalled receiver holds only
// the finished result; the next request is taken meanwhile but its own result
// waits until the register is free.
// Reset clears the control and loads the two config registers with 141 and 1.
`default_nettype none
module binary_curve_point_adder_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_idx_i,
  input  wire logic [31:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // first_x, first_y, second_x, second_y
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [63:0]       m_axis_tdata   // sum_x, sum_y
);

  bcpa_pkg::cmd_t  cmd;
  bcpa_pkg::stat_t stat;

  bcpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bcpa_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

`include "binary_curve_point_adder_unit_assert.svh"

  `BCPA_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `BCPA_ASSERT_SAME(a_no_step_when_done, cmd.op == bcpa_pkg::OP_INV_STEP, !stat.inv_done)
  `BCPA_ASSERT_NEXT(a_out_loads_valid, cmd.op == bcpa_pkg::OP_OUT, m_axis_tvalid)

endmodule
`default_nettype wire

### hdl/bcpa_ctrl.sv
`default_nettype none
module bcpa_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire bcpa_pkg::stat_t stat_i,
  output bcpa_pkg::cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLASS = 3'd1;
  localparam logic [2:0] S_INV   = 3'd2;
  localparam logic [2:0] S_MINIT = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_WB    = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cmd_o.op    = bcpa_pkg::OP_NONE;
    cmd_o.phase = phase_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = bcpa_pkg::OP_LOAD;
          state_d  = S_CLASS;
        end
      end
      S_CLASS: begin
        if (stat_i.inf2) begin
          cmd_o.op = bcpa_pkg::OP_RES_P1;
          state_d  = S_DONE;
        end else if (stat_i.inf1) begin
          cmd_o.op = bcpa_pkg::OP_RES_P2;
          state_d  = S_DONE;
        end else if (stat_i.same_x && (!stat_i.y_eq || stat_i.x1_zero)) begin
          cmd_o.op = bcpa_pkg::OP_RES_ZERO;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = bcpa_pkg::OP_INV_INIT;
          state_d  = S_INV;
        end
      end
      S_INV: begin
        if (stat_i.inv_done) begin
          phase_d = bcpa_pkg::PH_1;
          state_d = S_MINIT;
        end else begin
          cmd_o.op = bcpa_pkg::OP_INV_STEP;
        end
      end
      S_MINIT: begin
        cmd_o.op = bcpa_pkg::OP_MUL_INIT;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = bcpa_pkg::OP_MUL_STEP;
        if (stat_i.mul_last) state_d = S_WB;
      end
      S_WB: begin
        cmd_o.op = bcpa_pkg::OP_WB;
        if (phase_q == bcpa_pkg::PH_4 ||
            (phase_q == bcpa_pkg::PH_3 && !stat_i.same_x)) begin
          state_d = S_DONE;
        end else begin
          phase_d = phase_q + 2'd1;
          state_d = S_MINIT;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = bcpa_pkg::OP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= bcpa_pkg::PH_1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

### hdl/bcpa_datapath.sv
`default_nettype none
module bcpa_datapath (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_idx_i,
  input  wire bcpa_pkg::word_t cfg_data_i,
  input  wire logic [127:0]    in_data_i,
  output logic [63:0]          out_data_o,
  input  wire bcpa_pkg::cmd_t  cmd_i,
  output bcpa_pkg::stat_t      stat_o
);

  localparam int M = bcpa_pkg::ElemW;

  bcpa_pkg::word_t poly_q, a_q;
  bcpa_pkg::elem_t x1_q, y1_q, x2_q, y2_q, f_q, ca_q;
  bcpa_pkg::elem_t num_q, lam_q, rx_q, ry_q, tmp_q;
  bcpa_pkg::elem_t g1_q, g2_q;
  logic [M:0]          u_q, v_q;
  logic [bcpa_pkg::DegW-1:0] du_q, dv_q;
  bcpa_pkg::elem_t p_q, q_q, acc_q;
  logic [bcpa_pkg::CntW-1:0] cnt_q;
  bcpa_pkg::word_t out_x_q, out_y_q;

  logic [bcpa_pkg::DegW-1:0] shamt;
  logic [M:0]          v_sh;
  bcpa_pkg::elem_t     g_sh, inv_val, sx, acc_nx, p_sel, q_sel;
  logic                same_x;

  assign sx     = x1_q ^ x2_q;
  assign same_x = (x1_q == x2_q);
  assign shamt  = du_q - dv_q;
  assign v_sh   = v_q << shamt;
  assign g_sh   = g2_q << shamt;
  assign inv_val = (u_q == (M+1)'(1)) ? g1_q : '0;

  // MSB-first shift-and-add, reduce on overflow
  assign acc_nx = {acc_q[M-2:0], 1'b0} ^ (acc_q[M-1] ? f_q : '0) ^ (q_q[cnt_q] ? p_q : '0);

  always_comb begin
    p_sel = lam_q;
    q_sel = lam_q;
    case (cmd_i.phase)
      bcpa_pkg::PH_1: begin
        p_sel = inv_val;
        q_sel = num_q;
      end
      bcpa_pkg::PH_2: begin
        p_sel = lam_q;
        q_sel = lam_q;
      end
      bcpa_pkg::PH_3: begin
        p_sel = same_x ? x1_q : lam_q;
        q_sel = same_x ? x1_q : (x1_q ^ rx_q);
      end
      default: begin
        p_sel = lam_q ^ M'(1);
        q_sel = rx_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= 32'd141;
      a_q    <= 32'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bcpa_pkg::CFG_POLY: poly_q <= cfg_data_i;
        bcpa_pkg::CFG_A:    a_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      bcpa_pkg::OP_LOAD: begin
        x1_q <= bcpa_pkg::word_to_elem(in_data_i[31:0]);
        y1_q <= bcpa_pkg::word_to_elem(in_data_i[63:32]);
        x2_q <= bcpa_pkg::word_to_elem(in_data_i[95:64]);
        y2_q <= bcpa_pkg::word_to_elem(in_data_i[127:96]);
        f_q  <= bcpa_pkg::word_to_elem(poly_q);
        ca_q <= bcpa_pkg::word_to_elem(a_q);
      end
      bcpa_pkg::OP_RES_P1: begin
        rx_q <= x1_q;
        ry_q <= y1_q;
      end
      bcpa_pkg::OP_RES_P2: begin
        rx_q <= x2_q;
        ry_q <= y2_q;
      end
      bcpa_pkg::OP_RES_ZERO: begin
        rx_q <= '0;
        ry_q <= '0;
      end
      bcpa_pkg::OP_INV_INIT: begin
        u_q   <= {1'b0, same_x ? x1_q : sx};
        v_q   <= {1'b1, f_q};
        num_q <= same_x ? y1_q : (y1_q ^ y2_q);
        g1_q  <= M'(1);
        g2_q  <= '0;
        du_q  <= bcpa_pkg::DegW'(M - 1);
        dv_q  <= bcpa_pkg::DegW'(M);
      end
      bcpa_pkg::OP_INV_STEP: begin
        // degree of u found one bit a cycle; swap when u falls below v
        if (!u_q[du_q]) begin
          du_q <= du_q - 1'b1;
        end else if (du_q < dv_q) begin
          u_q  <= v_q;
          v_q  <= u_q;
          du_q <= dv_q;
          dv_q <= du_q;
          g1_q <= g2_q;
          g2_q <= g1_q;
        end else begin
          u_q  <= u_q ^ v_sh;
          g1_q <= g1_q ^ g_sh;
        end
      end
      bcpa_pkg::OP_MUL_INIT: begin
        p_q   <= p_sel;
        q_q   <= q_sel;
        acc_q <= '0;
        cnt_q <= bcpa_pkg::CntW'(M - 1);
      end
      bcpa_pkg::OP_MUL_STEP: begin
        acc_q <= acc_nx;
        cnt_q <= cnt_q - 1'b1;
      end
      bcpa_pkg::OP_WB: begin
        case (cmd_i.phase)
          bcpa_pkg::PH_1: lam_q <= acc_q ^ (same_x ? x1_q : '0);
          bcpa_pkg::PH_2: rx_q  <= acc_q ^ lam_q ^ ca_q ^ (same_x ? '0 : sx);
          bcpa_pkg::PH_3: begin
            if (same_x) tmp_q <= acc_q;
            else        ry_q  <= acc_q ^ rx_q ^ y1_q;
          end
          default: ry_q <= acc_q ^ tmp_q;
        endcase
      end
      bcpa_pkg::OP_OUT: begin
        out_x_q <= bcpa_pkg::elem_to_word(rx_q);
        out_y_q <= bcpa_pkg::elem_to_word(ry_q);
      end
      default: ;
    endcase
  end

  assign stat_o.inf1     = (x1_q == '0) && (y1_q == '0);
  assign stat_o.inf2     = (x2_q == '0) && (y2_q == '0);
  assign stat_o.same_x   = same_x;
  assign stat_o.y_eq     = (y1_q == y2_q);
  assign stat_o.x1_zero  = (x1_q == '0);
  assign stat_o.inv_done = (u_q == (M+1)'(1)) || (u_q == '0);
  assign stat_o.mul_last = (cnt_q == '0);

  assign out_data_o = {out_y_q, out_x_q};

endmodule
`default_nettype wire
